[sv/wmm_pkg.sv]
// Shared types and constants of the window min/max tracker.
// No dependencies; imported by every module of the block.
package wmm_pkg;

  localparam int unsigned WINDOW   = 120;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned ADDR_W   = $clog2(WINDOW);
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;    // store the accepted sample and restart the scan
    logic rd;    // issue one ring read and advance the read address
    logic load;  // move min/max and flags into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_last;   // read address is at the last filled entry
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

[sv/wmm_ctrl.sv]
// Sequencer of the window min/max tracker: accept, scan, drain, output.
// Depends on wmm_pkg.
module wmm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wmm_pkg::status_t status_i,
  output wmm_pkg::cmd_t    cmd_o
);
  import wmm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr = 1'b1;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data folds into min/max this cycle
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/wmm_datapath.sv]
// Datapath of the window min/max tracker: sample ring, scan pointers,
// min/max accumulators, previous extremes and output register. Depends on wmm_pkg.
module wmm_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wmm_pkg::cmd_t                    cmd_i,
  output wmm_pkg::status_t                 status_o,
  input  logic signed [wmm_pkg::SAMPLE_W-1:0] sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] window_min_o,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] window_max_o,
  output logic                             new_low_o,
  output logic                             new_high_o
);
  import wmm_pkg::*;

  sample_t           ring_mem [WINDOW];
  sample_t           rd_data_q;
  logic [ADDR_W-1:0] wr_slot_q, wr_slot_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  fill_m1;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic              rd_valid_q;
  logic              first_q, first_d;
  sample_t           lo_q, lo_d, hi_q, hi_d;
  sample_t           last_min_q, last_min_d, last_max_q, last_max_d;
  logic              out_valid_d;
  sample_t           win_min_q, win_max_q;
  logic              new_low_q, new_high_q;

  // Ring storage, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      ring_mem[wr_slot_q] <= sample_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= ring_mem[rd_addr_q];
    end
  end

  assign fill_m1           = fill_q - CNT_W'(1);
  assign status_o.rd_last  = (rd_addr_q == ADDR_W'(fill_m1));
  assign status_o.out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    wr_slot_d   = wr_slot_q;
    fill_d      = fill_q;
    rd_addr_d   = rd_addr_q;
    first_d     = first_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_min_d  = last_min_q;
    last_max_d  = last_max_q;
    out_valid_d = out_valid_o && out_stall_i;

    if (cmd_i.wr) begin
      wr_slot_d = (wr_slot_q == ADDR_W'(WINDOW - 1)) ? '0 : wr_slot_q + ADDR_W'(1);
      if (fill_q != CNT_W'(WINDOW)) begin
        fill_d = fill_q + CNT_W'(1);
      end
      rd_addr_d = '0;
      first_d   = 1'b1;
    end
    if (cmd_i.rd) begin
      rd_addr_d = rd_addr_q + ADDR_W'(1);
    end
    if (rd_valid_q) begin
      first_d = 1'b0;
      if (first_q || (rd_data_q < lo_q)) begin
        lo_d = rd_data_q;
      end
      if (first_q || (rd_data_q > hi_q)) begin
        hi_d = rd_data_q;
      end
    end
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      last_min_d  = lo_q;
      last_max_d  = hi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q   <= '0;
      fill_q      <= '0;
      rd_addr_q   <= '0;
      rd_valid_q  <= 1'b0;
      first_q     <= 1'b0;
      last_min_q  <= '0;
      last_max_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      wr_slot_q   <= wr_slot_d;
      fill_q      <= fill_d;
      rd_addr_q   <= rd_addr_d;
      rd_valid_q  <= cmd_i.rd;
      first_q     <= first_d;
      last_min_q  <= last_min_d;
      last_max_q  <= last_max_d;
      out_valid_o <= out_valid_d;
    end
  end

  // Accumulators and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.load) begin
      win_min_q  <= lo_q;
      win_max_q  <= hi_q;
      new_low_q  <= lo_q < last_min_q;
      new_high_q <= hi_q > last_max_q;
    end
  end

  assign window_min_o = win_min_q;
  assign window_max_o = win_max_q;
  assign new_low_o    = new_low_q;
  assign new_high_o   = new_high_q;

endmodule

[sv/window_min_max_tracker.sv]
// Top level of the window min/max tracker: controller plus datapath.
// Depends on wmm_pkg, wmm_ctrl and wmm_datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | sample_i
//  out     | output    | out_valid_o / out_stall_i | window_min_o, window_max_o,
//          |           |                           | new_low_o, new_high_o
//
// After its transfer a sample holds the input closed while the ring is rescanned over
// fill entries, fill being the number of stored samples (1 to 120), and until its result
// is loaded. The rescan issues one registered ring read per cycle, then folds in the
// last read and loads the result. Reset (rst_ni low, asynchronous) empties the window
// and clears the previous extremes to 0. A held result stalls only the next load.
module window_min_max_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wmm_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] window_min_o,
  output logic signed [wmm_pkg::SAMPLE_W-1:0] window_max_o,
  output logic                                new_low_o,
  output logic                                new_high_o
);
  import wmm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each sample: store, rescan the ring, fold in the last read, output.
  wmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the ring, the scan accumulators and the output register.
  wmm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_min_o (window_min_o),
    .window_max_o (window_max_o),
    .new_low_o    (new_low_o),
    .new_high_o   (new_high_o)
  );

`ifndef NO_ASSERTIONS
  // After a transfer the input stays closed while the ring is rescanned.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after a transfer");

  // A reported minimum never exceeds the reported maximum.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_min_o <= window_max_o))
    else $error("window minimum above window maximum");

  // No two of the write, read and load commands are ever issued together.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.wr, cmd.rd, cmd.load}) <= 1)
    else $error("overlapping datapath commands");
`endif

endmodule

[tb/sv/wmm_tb_pkg.sv]
// Scoreboard for the window min/max tracker testbench: predicts each result and checks it.
// Depends on wmm_pkg for the sample type and the window depth.
package wmm_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import wmm_pkg::*;

  typedef struct {
    sample_t win_min;
    sample_t win_max;
    logic    fell;
    logic    rose;
  } extremes_t;

  class extremes_scoreboard;
    sample_t     ring [WINDOW];
    int unsigned slot       = 0;
    int unsigned filled     = 0;
    sample_t     prev_min   = '0;
    sample_t     prev_max   = '0;
    extremes_t   awaited [$];
    int unsigned errors     = 0;
    int unsigned checked    = 0;
    int unsigned low_flags  = 0;
    int unsigned high_flags = 0;

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Store the sample, rescan the filled part of the ring, queue the result.
    function void note_sample(sample_t s);
      extremes_t e;
      ring[slot] = s;
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      if (filled < WINDOW) filled++;
      e.win_min = ring[0];
      e.win_max = ring[0];
      for (int i = 1; i < filled; i++) begin
        if (ring[i] < e.win_min) e.win_min = ring[i];
        if (ring[i] > e.win_max) e.win_max = ring[i];
      end
      e.fell   = e.win_min < prev_min;
      e.rose   = e.win_max > prev_max;
      prev_min = e.win_min;
      prev_max = e.win_max;
      awaited.push_back(e);
    endfunction

    function void mismatch(string what, int exp_val, int act_val);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
      errors++;
    endfunction

    function void check_result(sample_t mn, sample_t mx, logic lo, logic hi);
      extremes_t e;
      checked++;
      if (lo) low_flags++;
      if (hi) high_flags++;
      if (awaited.size() == 0) begin
        $display("%0t ns: result with none expected, actual min %0d max %0d low %0b high %0b",
                 $time, mn, mx, lo, hi);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (mn !== e.win_min) mismatch("window_min", e.win_min, mn);
      if (mx !== e.win_max) mismatch("window_max", e.win_max, mx);
      if (lo !== e.fell)    mismatch("new_low", e.fell, lo);
      if (hi !== e.rose)    mismatch("new_high", e.rose, hi);
    endfunction
  endclass

endpackage

[tb/sv/window_min_max_tracker_tb.sv]
// Testbench of the window min/max tracker: directed and random samples, random idling.
// Depends on wmm_pkg, wmm_tb_pkg and the window_min_max_tracker RTL.
module window_min_max_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmm_pkg::*;
  import wmm_tb_pkg::*;

  localparam int unsigned ITEMS       = 1200;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned HOLD_CYCLES = 600;  // long output hold-off, fills the block
  localparam int unsigned HOLD_AT     = 250;  // random item that triggers the hold-off
  localparam int unsigned PAUSE_AT    = 900;  // random item before which the sender drains
  localparam int unsigned CALM_FROM   = 500;  // random items with no idling on either side
  localparam int unsigned CALM_TO     = 700;
  localparam int unsigned SEGMENT     = 40;   // random items per stimulus shape
  localparam int unsigned TAIL_CYCLES = 250;  // beyond the worst rescan of a full window

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  sample_t sample_i;
  logic    out_valid_o;
  logic    out_stall_i;
  sample_t window_min_o;
  sample_t window_max_o;
  logic    new_low_o;
  logic    new_high_o;

  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned sent     = 0;

  extremes_scoreboard board = new();

  window_min_max_tracker DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_min_o (window_min_o),
    .window_max_o (window_max_o),
    .new_low_o    (new_low_o),
    .new_high_o   (new_high_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one sample, idling first at random; return at the edge of its transfer.
  // Valid is lowered only on an idle cycle, so each step sees one assignment at most.
  task automatic send_sample(input sample_t s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    // Hold the payload until the block takes it.
    while (in_stall_o) @(posedge clk_i);
    board.note_sample(s);
    sent++;
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    // First negative sample raises new_low against the reset minimum of 0, the first
    // positive one raises new_high; then the field extremes and alternating bit patterns.
    int directed_set [] = '{-5, 7, 0, -2048, 2047, -1, 1, 1365, -1366, -2047, 2046, 0};
    int          walk;
    int          drift;
    int unsigned shape;
    sample_t     s;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_set[k]) send_sample(sample_t'(directed_set[k]));

    walk  = 0;
    drift = 0;
    shape = 0;
    for (int n = 0; sent < ITEMS; n++) begin
      // Pick a new shape per segment: mostly a drifting random walk, so the window
      // extremes age out and both flags fire after the ring wraps.
      if (n % SEGMENT == 0) begin
        shape = $urandom_range(9);
        drift = 8 * (int'($urandom_range(2)) - 1);
      end
      calm = (n >= CALM_FROM && n < CALM_TO);
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) wait_for_drain();

      if (shape < 2) begin
        s = sample_t'($urandom_range(4095));
      end else if (shape < 8) begin
        walk += int'($urandom_range(96)) - 48 + drift;
        if (walk > 2047) walk = 2047;
        if (walk < -2048) walk = -2048;
        s = sample_t'(walk);
      end else begin
        case ($urandom_range(5))
          0:       s = sample_t'(-2048);
          1:       s = sample_t'(2047);
          2:       s = sample_t'(-2047);
          3:       s = sample_t'(2046);
          default: s = sample_t'($urandom_range(4095));
        endcase
      end
      send_sample(s);
    end
    in_valid_i <= 1'b0;

    // Drain, then watch a little longer for any result that should not come.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d samples (%0d directed), %0d results, %0d new_low, %0d new_high.",
             sent, directed_set.size(), board.checked, board.low_flags, board.high_flags);
    $display("Included a %0d-cycle output hold-off, a full drain and repeated window wraps.",
             HOLD_CYCLES);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("window_min_max_tracker_tb OK");
    end else begin
      $display("window_min_max_tracker_tb NOT OK");
    end
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch when asked.
  initial begin : receiver
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Check each output transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(window_min_o, window_max_o, new_low_o, new_high_o);
  end

  // Give up well beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("window_min_max_tracker_tb NOT OK");
    $finish;
  end

endmodule
